### hdl/nic_pkg.sv
// Shared constants, types and address helper for the nested interval end clamp.
package nic_pkg;

  localparam int THREADS     = 8;
  localparam int STACK_DEPTH = 32;

  localparam int TID_W   = 3;
  localparam int TIME_W  = 62;
  localparam int PTR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FILL_W  = $clog2(STACK_DEPTH + 1);
  localparam int FIDX_W  = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int MEM_DEPTH = THREADS * STACK_DEPTH;
  localparam int ADDR_W  = $clog2(MEM_DEPTH);

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_PUSH  = 5'b00100,
    S_DONE  = 5'b01000,
    S_SPARE = 5'b10000
  } state_e;

  // Flat entry address of slot ptr in the stack of thread tid.
  function automatic addr_t stk_addr(logic [TID_W-1:0] tid, logic [PTR_W-1:0] ptr);
    return ADDR_W'(tid) * ADDR_W'(STACK_DEPTH) + ADDR_W'(ptr);
  endfunction

endpackage

### hdl/nic_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nic_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/nested_interval_end_clamp.sv
// Top level: per-thread stacks of open end times that clamp nested events.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | input     | in_valid_i / in_stall_o | thread_id_i, start_time_i, end_time_i
//  out     | output    | out_valid_o/out_stall_i | end_time_out_o, was_clamped_o,
//          |           |                         | stack_overflow_o
//
// An event checks one stack entry per pass through the check state (one stack
// memory read each), popping entries that closed by its start, then passes the
// push state and the handoff state, where the result register loads. An event
// on a thread without a stack goes straight to the handoff state. The next
// event is accepted the cycle after the result loads. One event is in flight at
// a time.
// Reset clears the state, the output valid and the fill counts; stack entries
// above a fill count are never read, so the stack memory needs no clearing pass.
// A stalled result waits in the output register; the next event is accepted
// meanwhile and holds in the handoff state until the register frees.
module nested_interval_end_clamp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            thread_id_i,
  input  logic [61:0]           start_time_i,
  input  logic [61:0]           end_time_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [61:0]           end_time_out_o,
  output logic                  was_clamped_o,
  output logic                  stack_overflow_o
);
  import nic_pkg::*;

  state_e state_q, state_d;

  // Event being processed.
  logic [TID_W-1:0] tid_q, tid_d;
  time_t            start_q, start_d;
  time_t            end_q, end_d;
  fill_t            cur_fill_q, cur_fill_d;
  logic             clamped_q, clamped_d;
  logic             ovf_q, ovf_d;

  // Fill count per thread.
  fill_t            fill_q [THREADS];
  logic             fill_we;
  fill_t            fill_wdata;

  // Stack memory port signals.
  logic             mem_re, mem_we;
  addr_t            mem_raddr, mem_waddr;
  time_t            mem_rdata;

  // Output register.
  logic             out_valid_q;
  time_t            out_end_q;
  logic             out_clamped_q;
  logic             out_ovf_q;
  logic             out_load;

  logic             in_range;
  fill_t            in_fill;
  fill_t            fill_m1;
  fill_t            fill_m2;

  assign in_range = (32'(thread_id_i) < THREADS);
  assign in_fill  = fill_q[thread_id_i[FIDX_W-1:0]];
  assign fill_m1  = cur_fill_q - fill_t'(1);
  assign fill_m2  = cur_fill_q - fill_t'(2);

  assign in_stall_o = (state_q != S_IDLE);

  nic_ram #(
    .Width (TIME_W),
    .Depth (MEM_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (end_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d    = state_q;
    tid_d      = tid_q;
    start_d    = start_q;
    end_d      = end_q;
    cur_fill_d = cur_fill_q;
    clamped_d  = clamped_q;
    ovf_d      = ovf_q;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    fill_we    = 1'b0;
    fill_wdata = cur_fill_q;
    out_load   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          tid_d      = thread_id_i;
          start_d    = start_time_i;
          end_d      = end_time_i;
          cur_fill_d = in_fill;
          clamped_d  = 1'b0;
          ovf_d      = 1'b0;
          if (!in_range) begin
            // No stack for this thread: pass the end time through.
            state_d = S_DONE;
          end else if (in_fill == '0) begin
            state_d = S_PUSH;
          end else begin
            // Fetch the top of stack.
            mem_re    = 1'b1;
            mem_raddr = stk_addr(thread_id_i, PTR_W'(in_fill - fill_t'(1)));
            state_d   = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (mem_rdata <= start_q) begin
          // Top already closed: drop it and look one entry deeper.
          cur_fill_d = fill_m1;
          if (fill_m1 == '0) begin
            state_d = S_PUSH;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = stk_addr(tid_q, PTR_W'(fill_m2));
          end
        end else begin
          // Enclosing parent found: clamp to its end.
          if (end_q > mem_rdata) begin
            end_d     = mem_rdata;
            clamped_d = 1'b1;
          end
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        fill_we = 1'b1;
        if (cur_fill_q < fill_t'(STACK_DEPTH)) begin
          mem_we     = 1'b1;
          mem_waddr  = stk_addr(tid_q, PTR_W'(cur_fill_q));
          fill_wdata = cur_fill_q + fill_t'(1);
        end else begin
          // Stack full: drop the push and flag it.
          ovf_d = 1'b1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < THREADS; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (fill_we) begin
        fill_q[tid_q[FIDX_W-1:0]] <= fill_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tid_q      <= tid_d;
    start_q    <= start_d;
    end_q      <= end_d;
    cur_fill_q <= cur_fill_d;
    clamped_q  <= clamped_d;
    ovf_q      <= ovf_d;
    if (out_load) begin
      out_end_q     <= end_q;
      out_clamped_q <= clamped_q;
      out_ovf_q     <= ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign end_time_out_o   = out_end_q;
  assign was_clamped_o    = out_clamped_q;
  assign stack_overflow_o = out_ovf_q;

endmodule

### hdl/nic_chk.sv
// Port-level checker for the nested interval end clamp, bound to the top level.
module nic_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // One event at a time: busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input accepted while an event is still in flight");

  // A new result only appears at the end of work on an event.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an event in flight");

  // No result can be produced the cycle right after an accept.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after accept");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

bind nested_interval_end_clamp nic_chk u_nic_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
